// File: rtl/mstd_pkg.sv
`default_nettype none

package mstd_pkg;

	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_TRACK2 = 2'd1,
		MODE_TRACK1 = 2'd2,
		MODE_DONE   = 2'd3
	} mode_t;

	localparam logic [1:0] REQ_STROBE = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_REARM  = 2'd2;

	localparam logic [1:0] CFG_TIMEOUT_TICKS     = 2'd0;
	localparam logic [1:0] CFG_MIN_CHARS         = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT_COMPLETES = 2'd2;
	localparam logic [1:0] CFG_LINE_INVERTED     = 2'd3;

	localparam logic [4:0] SENT_TRACK2 = 5'h0B;
	localparam logic [6:0] SENT_TRACK1 = 7'h45;
	localparam logic [4:0] END_TRACK2  = 5'h1F;
	localparam logic [6:0] END_TRACK1  = 7'h1F;
	localparam logic [2:0] LEN_TRACK2  = 3'd5;
	localparam logic [2:0] LEN_TRACK1  = 3'd7;
	localparam logic [7:0] IDLE_MAX    = 8'hFF;

	localparam logic [7:0] RST_TIMEOUT_TICKS = 8'd7;
	localparam logic [6:0] RST_MIN_CHARS     = 7'd5;

	typedef struct packed {
		logic [7:0] timeout_ticks;
		logic [6:0] min_chars;
		logic       timeout_completes;
		logic       line_inverted;
	} cfg_t;

	typedef struct packed {
		logic       char_valid;
		logic [5:0] char_value;
		logic [5:0] char_index;
		logic       track_one;
		logic       frame_done;
		logic       frame_error;
		logic       timed_out;
		logic       card_ready;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/mstd_cfg.sv
`default_nettype none

module mstd_cfg
	import mstd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks     <= RST_TIMEOUT_TICKS;
			cfg_q.min_chars         <= RST_MIN_CHARS;
			cfg_q.timeout_completes <= 1'b0;
			cfg_q.line_inverted     <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TIMEOUT_TICKS:     cfg_q.timeout_ticks     <= cfg_data;
				CFG_MIN_CHARS:         cfg_q.min_chars         <= cfg_data[6:0];
				CFG_TIMEOUT_COMPLETES: cfg_q.timeout_completes <= cfg_data[0];
				CFG_LINE_INVERTED:     cfg_q.line_inverted     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/mstd_engine.sv
`default_nettype none

module mstd_engine
	import mstd_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [1:0] req,
	input  wire logic       raw,
	input  wire cfg_t       cfg,
	output res_t            res
);

	localparam int CW   = $clog2(MAX_CHARS);
	localparam int CMPW = ((CW > 7) ? CW : 7) + 1;
	localparam logic [CMPW-1:0] OVF_LIMIT = CMPW'(MAX_CHARS - 2);

	mode_t           mode_q, mode_n;
	logic [6:0]      win_q, win_n;
	logic [2:0]      bc_q, bc_n;
	logic            par_q, par_n;
	logic [CW-1:0]   cc_q, cc_n;
	logic [7:0]      idle_q, idle_n;
	logic            ready_q, ready_n;
	logic            trk_q, trk_n;

	logic            one;
	logic [6:0]      win_sh;
	logic [2:0]      bc_inc;
	logic            par_x;
	logic [2:0]      len;
	logic [5:0]      code;
	logic            is_end;
	logic [CMPW-1:0] pos_w;
	logic [CMPW-1:0] cc_inc;
	logic [7:0]      idle_inc;
	logic            v_n, done_n, err_n, tout_n, restart;

	assign one      = cfg.line_inverted ? ~raw : raw;
	assign win_sh   = {one, win_q[6:1]};
	assign bc_inc   = bc_q + 3'd1;
	assign par_x    = par_q ^ one;
	assign len      = (mode_q == MODE_TRACK2) ? LEN_TRACK2 : LEN_TRACK1;
	assign pos_w    = CMPW'(cc_q);
	assign cc_inc   = pos_w + CMPW'(1);
	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 8'd1;

	always_comb begin
		if (mode_q == MODE_TRACK2) begin
			code   = {2'b00, win_sh[5:2]};
			is_end = (win_sh[6:2] == END_TRACK2);
		end else begin
			code   = win_sh[5:0];
			is_end = (win_sh == END_TRACK1);
		end
	end

	// next state
	always_comb begin
		mode_n  = mode_q;
		win_n   = win_q;
		bc_n    = bc_q;
		par_n   = par_q;
		cc_n    = cc_q;
		idle_n  = idle_q;
		ready_n = ready_q;
		trk_n   = trk_q;
		v_n     = 1'b0;
		done_n  = 1'b0;
		err_n   = 1'b0;
		tout_n  = 1'b0;
		restart = 1'b0;
		case (req)
			REQ_STROBE: begin
				idle_n = '0;
				if (mode_q != MODE_DONE) begin
					win_n = win_sh;
				end
				case (mode_q)
					MODE_SEARCH: begin
						if (win_sh[6:2] == SENT_TRACK2) begin
							mode_n = MODE_TRACK2;
							trk_n  = 1'b0;
							bc_n   = '0;
							par_n  = 1'b0;
						end else if (win_sh == SENT_TRACK1) begin
							mode_n = MODE_TRACK1;
							trk_n  = 1'b1;
							bc_n   = '0;
							par_n  = 1'b0;
						end
					end
					MODE_TRACK2, MODE_TRACK1: begin
						bc_n  = bc_inc;
						par_n = par_x;
						if (bc_inc == len) begin
							if (!par_x) begin
								err_n = 1'b1;
							end else begin
								bc_n  = '0;
								par_n = 1'b0;
								cc_n  = cc_inc[CW-1:0];
								if (cc_inc > OVF_LIMIT) begin
									err_n = 1'b1;
								end else if (is_end && (cc_inc < CMPW'(cfg.min_chars))) begin
									err_n = 1'b1;
								end else begin
									v_n = 1'b1;
									if (is_end) begin
										mode_n  = MODE_DONE;
										ready_n = 1'b1;
										done_n  = 1'b1;
									end
								end
							end
							restart = err_n;
						end
					end
					default: ;
				endcase
			end
			REQ_TICK: begin
				if (!ready_q && (cc_q != '0)) begin
					idle_n = idle_inc;
					if (idle_inc > cfg.timeout_ticks) begin
						if (cfg.timeout_completes) begin
							ready_n = 1'b1;
							mode_n  = MODE_DONE;
							done_n  = 1'b1;
						end else begin
							restart = 1'b1;
							tout_n  = 1'b1;
						end
					end
				end
			end
			REQ_REARM: begin
				ready_n = 1'b0;
				restart = 1'b1;
			end
			default: ;
		endcase
		if (restart) begin
			mode_n = MODE_SEARCH;
			win_n  = '0;
			bc_n   = '0;
			par_n  = 1'b0;
			cc_n   = '0;
			idle_n = '0;
			trk_n  = 1'b0;
		end
	end

	// result word
	always_comb begin
		res.char_valid  = v_n;
		res.char_value  = v_n ? code : '0;
		res.char_index  = v_n ? pos_w[5:0] : '0;
		res.track_one   = trk_n;
		res.frame_done  = done_n;
		res.frame_error = err_n;
		res.timed_out   = tout_n;
		res.card_ready  = ready_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SEARCH;
			win_q   <= '0;
			bc_q    <= '0;
			par_q   <= 1'b0;
			cc_q    <= '0;
			idle_q  <= '0;
			ready_q <= 1'b0;
			trk_q   <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_n;
			win_q   <= win_n;
			bc_q    <= bc_n;
			par_q   <= par_n;
			cc_q    <= cc_n;
			idle_q  <= idle_n;
			ready_q <= ready_n;
			trk_q   <= trk_n;
		end
	end

endmodule

`default_nettype wire

// File: rtl/magstripe_track_bit_decoder_core.sv
`default_nettype none

// Magnetic-stripe track I / track II bit decoder. Each input word is a data
// bit strobe, a tick or a rearm request; each one yields exactly one result
// word carrying any decoded character with its frame index and the frame
// status flags. A word is registered at the input, decoded against the frame
// state and registered at the output, so one word is taken every cycle;
// throughput drops only while the output is stalled with both registers full.
// Configuration must be written through cfg_wr_en/cfg_index/cfg_data only
// while idle; the block itself does not enforce this.
module magstripe_track_bit_decoder_core
	import mstd_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,

	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] req_type,
	input  wire logic       data_bit,

	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            char_valid,
	output logic [5:0]      char_value,
	output logic [5:0]      char_index,
	output logic            track_one,
	output logic            frame_done,
	output logic            frame_error,
	output logic            timed_out,
	output logic            card_ready
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_s2;
	logic       valid_s1;
	logic [1:0] req_s1;
	logic       bit_s1;
	logic       valid_s2;
	logic       advance;
	logic       take;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	mstd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mstd_engine #(
		.MAX_CHARS (MAX_CHARS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.raw    (bit_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req_type;
			bit_s1 <= data_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign char_valid  = res_s2.char_valid;
	assign char_value  = res_s2.char_value;
	assign char_index  = res_s2.char_index;
	assign track_one   = res_s2.track_one;
	assign frame_done  = res_s2.frame_done;
	assign frame_error = res_s2.frame_error;
	assign timed_out   = res_s2.timed_out;
	assign card_ready  = res_s2.card_ready;

endmodule

`default_nettype wire
